/* design/ste_pkg.sv */
// Shared types and constants for the symbol table engine.
// Defines the table entry record, cell commands, status and action codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

  localparam int KEY_W   = 160;
  localparam int BYTES   = KEY_W / 8;
  localparam int ADDR_W  = 32;
  localparam int POS_W   = 6;
  localparam int CNT_W   = POS_W + 1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  kind;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_ROTATE  = 2'd1,
    CELL_COMPACT = 2'd2,
    CELL_WRITE   = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [POS_W-1:0] sel;
    entry_t           wdata;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_DUMP   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

endpackage

`default_nettype wire

/* design/ste_cell.sv */
// One table cell: holds a single entry and takes its neighbor's entry or the write data on command.
// Depends on ste_pkg for the entry record and cell command.
`timescale 1ns / 1ps
`default_nettype none

module ste_cell #(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire ste_pkg::cell_cmd_t cmd,
  input  wire ste_pkg::entry_t    next_entry,
  output ste_pkg::entry_t         entry
);
  import ste_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

  always_ff @(posedge clk) begin
    case (cmd.mode)
      CELL_ROTATE: begin
        entry <= next_entry;
      end
      CELL_COMPACT: begin
        if (MY_POS >= cmd.sel) begin
          entry <= next_entry;
        end
      end
      CELL_WRITE: begin
        if (MY_POS == cmd.sel) begin
          entry <= cmd.wdata;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/ste_ctrl.sv */
// Sequencer of the symbol table engine: scans the cell ring, tracks occupancy,
// and holds the result register. Depends on ste_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ste_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ste_pkg::act_t                   action,
  input  wire logic [ste_pkg::KEY_W-1:0]       key_in,
  input  wire logic [ste_pkg::KEY_W-1:0]       kind_in,
  input  wire logic [ste_pkg::ADDR_W-1:0]      addr_in,
  input  wire ste_pkg::entry_t                 head,
  output ste_pkg::cell_cmd_t                   cmd,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ste_pkg::status_t                     out_status,
  output logic [ste_pkg::POS_W-1:0]            out_pos,
  output ste_pkg::entry_t                      out_entry,
  output logic                                 out_last
);
  import ste_pkg::*;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [POS_W-1:0] LAST_STEP  = POS_W'(DEPTH - 1);

  function automatic logic [KEY_W-1:0] canon(input logic [KEY_W-1:0] s);
    logic             ended;
    logic [KEY_W-1:0] d;
    ended = 1'b0;
    d     = s;
    for (int i = 0; i < BYTES; i++) begin
      if (ended) begin
        d[i*8 +: 8] = 8'h00;
      end else if (s[i*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return d;
  endfunction

  state_t            state;
  state_t            state_next;
  act_t              op;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  kind;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  count;
  logic [POS_W-1:0]  step;
  logic              found;
  logic [POS_W-1:0]  hit_pos;
  entry_t            hit_entry;

  logic              accept;
  logic              slot_free;
  logic              in_range;
  logic              emit;
  logic              advance;
  logic              head_match;
  logic              load_out;
  status_t           res_status;
  logic [POS_W-1:0]  res_pos;
  entry_t            res_entry;
  logic              res_last;
  entry_t            new_entry;

  assign in_ready   = (state == S_IDLE) && !rst;
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign in_range   = ({1'b0, step} < count);
  assign emit       = (state == S_SCAN) && (op == ACT_DUMP) && in_range;
  assign advance    = (state == S_SCAN) && (!emit || slot_free);
  assign head_match = (head.key == key);
  assign new_entry  = '{key: key, kind: kind, addr: addr};

  always_comb begin
    state_next = state;
    cmd.mode   = CELL_HOLD;
    cmd.sel    = hit_pos;
    cmd.wdata  = new_entry;
    load_out   = 1'b0;
    res_status = STAT_OK;
    res_pos    = '0;
    res_entry  = '0;
    res_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((action == ACT_DUMP) && (count == '0)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (emit && slot_free) begin
          load_out  = 1'b1;
          res_pos   = step;
          res_entry = head;
          res_last  = ((CNT_W'(step) + CNT_W'(1)) == count);
        end
        if (advance) begin
          cmd.mode = CELL_ROTATE;
          if (step == LAST_STEP) begin
            state_next = (op == ACT_DUMP) ? S_IDLE : S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          case (op)
            ACT_INSERT: begin
              if (found) begin
                res_status = STAT_DUP;
                res_pos    = hit_pos;
                res_entry  = hit_entry;
              end else if (count == FULL_COUNT) begin
                res_status = STAT_FULL;
              end else begin
                res_pos   = count[POS_W-1:0];
                res_entry = new_entry;
                cmd.mode  = CELL_WRITE;
                cmd.sel   = count[POS_W-1:0];
              end
            end
            ACT_SEARCH: begin
              if (found) begin
                res_pos   = hit_pos;
                res_entry = hit_entry;
              end else begin
                res_status = STAT_NOTFOUND;
              end
            end
            ACT_DELETE: begin
              if (found) begin
                res_pos   = hit_pos;
                res_entry = hit_entry;
                cmd.mode  = CELL_COMPACT;
              end else begin
                res_status = STAT_NOTFOUND;
              end
            end
            default: begin
              res_status = STAT_EMPTY;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        step  <= '0;
        found <= 1'b0;
      end else if (advance) begin
        step <= (step == LAST_STEP) ? '0 : step + POS_W'(1);
        if ((op != ACT_DUMP) && in_range && !found && head_match) begin
          found <= 1'b1;
        end
      end
      if (cmd.mode == CELL_WRITE) begin
        count <= count + CNT_W'(1);
      end else if (cmd.mode == CELL_COMPACT) begin
        count <= count - CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= action;
      key  <= canon(key_in);
      kind <= canon(kind_in);
      addr <= addr_in;
    end
    if (advance && (op != ACT_DUMP) && in_range && !found && head_match) begin
      hit_pos   <= step;
      hit_entry <= head;
    end
    if (load_out) begin
      out_status <= res_status;
      out_pos    <= res_pos;
      out_entry  <= res_entry;
      out_last   <= res_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (count == $past(count)))
    else $error("occupancy changed during a scan");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> ((state == S_SCAN) && (op == ACT_DUMP)))
    else $error("non-final result outside a dump scan");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.mode == CELL_WRITE) |-> (count < FULL_COUNT))
    else $error("append into a full table");

  assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && found) |-> ({1'b0, hit_pos} < count))
    else $error("hit position beyond occupancy");

endmodule

`default_nettype wire

/* design/symbol_table_engine.sv */
// Top level of the symbol table engine: a ring of DEPTH entry cells and its sequencer.
// Depends on ste_pkg, ste_cell and ste_ctrl.
//
// Usage: an item on the input channel (in_valid/in_ready) carries an action, a 20-byte
// key, a 20-byte type string and an address. Keys and types are cut at their first
// zero byte. Results leave on the output channel (out_valid/out_ready); last marks the
// final result of an item. Insert, search and delete give one result, a dump gives one
// result per stored entry, or a single empty status when the table is empty.
// Every item except a dump of an empty table rotates the cell ring once around,
// comparing the head cell with the key or, in a dump, giving it as a result. An insert,
// search or delete gives its result from the finish state after the scan, and the next
// item is accepted once that result is registered; a dump gives each stored entry in the
// scan and takes the next item when it ends; a dump of an empty table skips the scan
// and goes to the finish state. A stalled receiver holds the output register;
// during a dump the ring stops rotating until the pending result is taken, and at the
// end of a scan the sequencer waits for a free output register. No item is accepted
// during reset. Reset empties the table; stored contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module symbol_table_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic [63:0]        key_part0,
  input  wire logic [63:0]        key_part1,
  input  wire logic [31:0]        key_part2,
  input  wire logic [63:0]        kind_part0,
  input  wire logic [63:0]        kind_part1,
  input  wire logic [31:0]        kind_part2,
  input  wire logic signed [31:0] addr_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic [5:0]              position,
  output logic [63:0]             out_key_part0,
  output logic [63:0]             out_key_part1,
  output logic [31:0]             out_key_part2,
  output logic [63:0]             out_kind_part0,
  output logic [63:0]             out_kind_part1,
  output logic [31:0]             out_kind_part2,
  output logic signed [31:0]      out_addr,
  output logic                    last
);
  import ste_pkg::*;

  entry_t    cells [DEPTH];
  cell_cmd_t cell_cmd;
  status_t   res_status;
  entry_t    res_entry;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ste_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .next_entry (cells[(i + 1) % DEPTH]),
      .entry      (cells[i])
    );
  end

  ste_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (act_t'(action)),
    .key_in     ({key_part2, key_part1, key_part0}),
    .kind_in    ({kind_part2, kind_part1, kind_part0}),
    .addr_in    (addr_value),
    .head       (cells[0]),
    .cmd        (cell_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (res_status),
    .out_pos    (position),
    .out_entry  (res_entry),
    .out_last   (last)
  );

  assign status         = res_status;
  assign out_key_part0  = res_entry.key[63:0];
  assign out_key_part1  = res_entry.key[127:64];
  assign out_key_part2  = res_entry.key[159:128];
  assign out_kind_part0 = res_entry.kind[63:0];
  assign out_kind_part1 = res_entry.kind[127:64];
  assign out_kind_part2 = res_entry.kind[159:128];
  assign out_addr       = $signed(res_entry.addr);

endmodule

`default_nettype wire

/* tb/tb_symbol_table_engine.sv */
// Self-checking testbench for symbol_table_engine: a directed table of stimulus,
// then phases of random inserts, searches, deletes and dumps, checked against
// an in-bench model of the symbol table. Depends on ste_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_symbol_table_engine;
  import ste_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int POOL_SIZE = 96;
  localparam int ITEM_GOAL = 410;
  localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] JUNK_A = {BYTES{8'hA5}};
  localparam logic [KEY_W-1:0] JUNK_B = {BYTES{8'h5A}};
  localparam logic [KEY_W-1:0] EMPTY_JUNK = {{(KEY_W-8){1'b1}}, 8'h00};

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_t;

  typedef struct packed {
    status_t          st;
    logic [POS_W-1:0] pos;
    entry_t           ent;
    logic             lst;
  } result_t;

  typedef struct {
    act_t              act;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  kind;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    status_t           typed_st;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] action;
  logic [63:0] key_part0;
  logic [63:0] key_part1;
  logic [31:0] key_part2;
  logic [63:0] kind_part0;
  logic [63:0] kind_part1;
  logic [31:0] kind_part2;
  logic signed [31:0] addr_value;
  logic out_valid;
  logic out_ready;
  logic [2:0] status;
  logic [5:0] position;
  logic [63:0] out_key_part0;
  logic [63:0] out_key_part1;
  logic [31:0] out_key_part2;
  logic [63:0] out_kind_part0;
  logic [63:0] out_kind_part1;
  logic [31:0] out_kind_part2;
  logic signed [31:0] out_addr;
  logic last;

  result_t pending_results[$];
  plan_row_t plan_rows[$];
  logic [KEY_W-1:0] name_pool[POOL_SIZE];
  entry_t tbl_entries[TBL_DEPTH];
  int tbl_count = 0;

  int err_count = 0;
  int shown_errs = 0;
  int items_sent = 0;
  int results_taken = 0;
  int n_dump = 0;
  int n_dup = 0;
  int n_full = 0;
  int n_miss = 0;
  int peak_count = 0;
  bit calm = 1'b0;
  bit hold_done = 1'b0;

  symbol_table_engine #(.DEPTH(TBL_DEPTH)) u_top (.*);

  always #4 clk = ~clk;

  function automatic logic [KEY_W-1:0] canon_text(input logic [KEY_W-1:0] s);
    logic [KEY_W-1:0] v;
    bit ended;
    int b;
    v = s;
    ended = 1'b0;
    for (b = 0; b < BYTES; b++) begin
      if (ended) v[8*b +: 8] = 8'h00;
      else if (v[8*b +: 8] == 8'h00) ended = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [KEY_W-1:0] add_junk(input logic [KEY_W-1:0] s);
    logic [KEY_W-1:0] v;
    bit ended;
    int b;
    v = s;
    ended = 1'b0;
    for (b = 0; b < BYTES; b++) begin
      if (ended) v[8*b +: 8] = 8'($urandom_range(0, 255));
      else if (v[8*b +: 8] == 8'h00) ended = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [KEY_W-1:0] ascii_text(input string s);
    logic [KEY_W-1:0] v;
    int b;
    v = '0;
    for (b = 0; b < s.len() && b < BYTES; b++) v[8*b +: 8] = s[b];
    return v;
  endfunction

  function automatic logic [KEY_W-1:0] random_text();
    logic [KEY_W-1:0] v;
    int len;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom};
    len = $urandom_range(0, BYTES);
    if (len < BYTES) v[8*len +: 8] = 8'h00;
    return v;
  endfunction

  function automatic result_t make_result(input status_t s, input int p, input entry_t e,
                                          input logic l);
    result_t x;
    x.st = s;
    x.pos = p[POS_W-1:0];
    x.ent = e;
    x.lst = l;
    return x;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(input act_t a, input logic [KEY_W-1:0] k, input logic [KEY_W-1:0] kd,
                         input logic [ADDR_W-1:0] ad, input bit typed, input status_t ts);
    plan_row_t row;
    row.act = a;
    row.key = k;
    row.kind = kd;
    row.addr = ad;
    row.typed = typed;
    row.typed_st = ts;
    plan_rows.push_back(row);
  endtask

  task automatic predict_table(input act_t a, input logic [KEY_W-1:0] key_in,
                               input logic [KEY_W-1:0] kind_in,
                               input logic [ADDR_W-1:0] addr_in);
    logic [KEY_W-1:0] k;
    entry_t fresh;
    int hit;
    int i;
    k = canon_text(key_in);
    hit = -1;
    for (i = 0; i < tbl_count; i++)
      if (hit < 0 && tbl_entries[i].key == k) hit = i;
    case (a)
      ACT_INSERT: begin
        if (hit >= 0) begin
          n_dup++;
          pending_results.push_back(make_result(STAT_DUP, hit, tbl_entries[hit], 1'b1));
        end else if (tbl_count >= TBL_DEPTH) begin
          n_full++;
          pending_results.push_back(make_result(STAT_FULL, 0, '0, 1'b1));
        end else begin
          fresh.key = k;
          fresh.kind = canon_text(kind_in);
          fresh.addr = addr_in;
          tbl_entries[tbl_count] = fresh;
          pending_results.push_back(make_result(STAT_OK, tbl_count, fresh, 1'b1));
          tbl_count++;
          if (tbl_count > peak_count) peak_count = tbl_count;
        end
      end
      ACT_SEARCH: begin
        if (hit >= 0) begin
          pending_results.push_back(make_result(STAT_OK, hit, tbl_entries[hit], 1'b1));
        end else begin
          n_miss++;
          pending_results.push_back(make_result(STAT_NOTFOUND, 0, '0, 1'b1));
        end
      end
      ACT_DELETE: begin
        if (hit >= 0) begin
          pending_results.push_back(make_result(STAT_OK, hit, tbl_entries[hit], 1'b1));
          for (i = hit; i + 1 < tbl_count; i++) tbl_entries[i] = tbl_entries[i+1];
          tbl_count--;
        end else begin
          n_miss++;
          pending_results.push_back(make_result(STAT_NOTFOUND, 0, '0, 1'b1));
        end
      end
      default: begin
        n_dump++;
        if (tbl_count == 0) begin
          pending_results.push_back(make_result(STAT_EMPTY, 0, '0, 1'b1));
        end else begin
          for (i = 0; i < tbl_count; i++)
            pending_results.push_back(make_result(STAT_OK, i, tbl_entries[i],
                                                  i + 1 == tbl_count));
        end
      end
    endcase
  endtask

  task automatic push_item(input act_t act_in, input logic [KEY_W-1:0] key_in,
                           input logic [KEY_W-1:0] kind_in, input logic [ADDR_W-1:0] addr_in,
                           input bit typed, input status_t typed_st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act_in;
    key_part0 <= key_in[63:0];
    key_part1 <= key_in[127:64];
    key_part2 <= key_in[159:128];
    kind_part0 <= kind_in[63:0];
    kind_part1 <= kind_in[127:64];
    kind_part2 <= kind_in[159:128];
    addr_value <= addr_in;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
    if (typed) begin
      if (typed_st == STAT_NOTFOUND) n_miss++;
      if (act_in == ACT_DUMP) n_dump++;
      pending_results.push_back(make_result(typed_st, 0, '0, 1'b1));
    end else begin
      predict_table(act_in, key_in, kind_in, addr_in);
    end
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int r;
    r = $urandom_range(0, 99);
    if (tbl_count > 0 && r < 50) k = tbl_entries[$urandom_range(0, tbl_count - 1)].key;
    else if (r < 90) k = name_pool[$urandom_range(0, POOL_SIZE - 1)];
    else k = {$urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 1) == 1) k = add_junk(k);
    return k;
  endfunction

  task automatic check_result();
    result_t got;
    result_t want;
    got.st = status_t'(status);
    got.pos = position;
    got.ent.key = {out_key_part2, out_key_part1, out_key_part0};
    got.ent.kind = {out_kind_part2, out_kind_part1, out_kind_part0};
    got.ent.addr = out_addr;
    got.lst = last;
    results_taken++;
    if (pending_results.size() == 0) begin
      err_count++;
      if (shown_errs < 10) begin
        shown_errs++;
        $display("[%0t] result with nothing expected: status %0d position %0d", $realtime,
                 status, position);
      end
    end else begin
      want = pending_results.pop_front();
      if (got.st !== want.st || got.pos !== want.pos || got.ent.key !== want.ent.key ||
          got.ent.kind !== want.ent.kind || got.ent.addr !== want.ent.addr ||
          got.lst !== want.lst) begin
        err_count++;
        if (shown_errs < 10) begin
          shown_errs++;
          $display("[%0t] mismatch: status %0d/%0d position %0d/%0d last %b/%b",
                   $realtime, want.st, got.st, want.pos, got.pos, want.lst, got.lst);
          $display("  key  exp %h got %h", want.ent.key, got.ent.key);
          $display("  kind exp %h got %h", want.ent.kind, got.ent.kind);
          $display("  addr exp %h got %h", want.ent.addr, got.ent.addr);
        end
      end
    end
  endtask

  // Receiver: random back-pressure plus one long hold-off that fills the engine.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready === 1'b1) check_result();
      if (stall_left == 0 && !hold_done && results_taken >= 60) begin
        hold_done = 1'b1;
        stall_left = 500;
      end
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && r >= 70) begin
        stall_left = (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb_symbol_table_engine: done, errors");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] nm_ab;
    logic [KEY_W-1:0] k;
    logic [ADDR_W-1:0] ad;
    mix_t mix;
    act_t a;
    int phase_no;
    int phase_len;
    int fill_cursor;
    int i;
    int r;

    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_INSERT;
    key_part0 <= '0;
    key_part1 <= '0;
    key_part2 <= '0;
    kind_part0 <= '0;
    kind_part1 <= '0;
    kind_part2 <= '0;
    addr_value <= '0;

    for (i = 0; i < POOL_SIZE; i++) name_pool[i] = canon_text(random_text());
    nm_ab = ascii_text("ab");

    add_row(ACT_DUMP, '0, '0, '0, 1'b1, STAT_EMPTY);
    add_row(ACT_SEARCH, nm_ab, '0, '0, 1'b1, STAT_NOTFOUND);
    add_row(ACT_DELETE, nm_ab, '0, '0, 1'b1, STAT_NOTFOUND);
    add_row(ACT_INSERT, ALL_ONES, ALL_ONES, 32'h7FFF_FFFF, 1'b0, STAT_OK);
    add_row(ACT_INSERT, '0, '0, 32'h8000_0000, 1'b0, STAT_OK);
    add_row(ACT_INSERT, nm_ab | (JUNK_A << 24), ascii_text("int") | (JUNK_B << 32),
            32'hFFFF_FFFF, 1'b0, STAT_OK);
    add_row(ACT_INSERT, nm_ab | (JUNK_B << 24), ascii_text("char"), '0, 1'b0, STAT_OK);
    add_row(ACT_INSERT, EMPTY_JUNK, ALL_ONES, 32'd1, 1'b0, STAT_OK);
    add_row(ACT_SEARCH, nm_ab | (JUNK_B << 24), '0, '0, 1'b0, STAT_OK);
    add_row(ACT_SEARCH, ALL_ONES, '0, '0, 1'b0, STAT_OK);
    add_row(ACT_DUMP, JUNK_A, JUNK_B, 32'hFFFF_FFFF, 1'b0, STAT_OK);
    add_row(ACT_DELETE, EMPTY_JUNK, '0, '0, 1'b0, STAT_OK);
    add_row(ACT_DUMP, '0, '0, '0, 1'b0, STAT_OK);
    add_row(ACT_SEARCH, '0, '0, '0, 1'b1, STAT_NOTFOUND);
    add_row(ACT_INSERT, ascii_text("abc"), ascii_text("float"), 32'd123, 1'b0, STAT_OK);
    add_row(ACT_DELETE, ALL_ONES, '0, '0, 1'b0, STAT_OK);
    add_row(ACT_DELETE, ascii_text("abc"), '0, '0, 1'b0, STAT_OK);
    add_row(ACT_DUMP, '0, '0, '0, 1'b0, STAT_OK);
    add_row(ACT_DELETE, nm_ab, '0, '0, 1'b0, STAT_OK);
    add_row(ACT_DUMP, '0, '0, '0, 1'b1, STAT_EMPTY);
    add_row(ACT_INSERT, ascii_text("abcdefghijklmnopqrst"), ascii_text("twenty_byte_type_str"),
            -32'sd5, 1'b0, STAT_OK);
    add_row(ACT_SEARCH, ascii_text("abcdefghijklmnopqrs"), '0, '0, 1'b1, STAT_NOTFOUND);
    add_row(ACT_DUMP, '0, '0, '0, 1'b0, STAT_OK);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_rows[i])
      push_item(plan_rows[i].act, plan_rows[i].key, plan_rows[i].kind, plan_rows[i].addr,
                plan_rows[i].typed, plan_rows[i].typed_st);

    // Random phases: fill bursts favour inserts, drain bursts favour deletes.
    phase_no = 0;
    fill_cursor = 0;
    while (items_sent < ITEM_GOAL) begin
      mix = (phase_no == 0) ? MODE_FILL : mix_t'($urandom_range(0, 2));
      phase_len = (phase_no == 0) ? 90 : $urandom_range(20, 60);
      if (phase_no == 1 || $urandom_range(0, 3) == 0) drain_outputs();
      calm = (phase_no > 0 && $urandom_range(0, 4) == 0);
      for (i = 0; i < phase_len && items_sent < ITEM_GOAL; i++) begin
        r = $urandom_range(0, 99);
        case (mix)
          MODE_FILL:  a = (r < 78) ? ACT_INSERT : (r < 88) ? ACT_SEARCH :
                          (r < 96) ? ACT_DELETE : ACT_DUMP;
          MODE_DRAIN: a = (r < 15) ? ACT_INSERT : (r < 35) ? ACT_SEARCH :
                          (r < 95) ? ACT_DELETE : ACT_DUMP;
          default:    a = (r < 35) ? ACT_INSERT : (r < 65) ? ACT_SEARCH :
                          (r < 93) ? ACT_DELETE : ACT_DUMP;
        endcase
        if (a == ACT_INSERT && mix == MODE_FILL && $urandom_range(0, 99) < 80) begin
          k = name_pool[fill_cursor];
          if ($urandom_range(0, 1) == 1) k = add_junk(k);
          fill_cursor = (fill_cursor + 1) % POOL_SIZE;
        end else begin
          k = pick_key();
        end
        r = $urandom_range(0, 19);
        ad = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF : $urandom;
        push_item(a, k, random_text(), ad, 1'b0, STAT_OK);
      end
      phase_no++;
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TBL_DEPTH + 8) @(posedge clk);
    if (pending_results.size() != 0) err_count++;

    $display("Sent %0d items (%0d dumps), checked %0d results, peak occupancy %0d.",
             items_sent, n_dump, results_taken, peak_count);
    $display("Statuses seen: %0d duplicate, %0d full, %0d not found; %0d failures.",
             n_dup, n_full, n_miss, err_count);
    if (err_count == 0) begin
      $display("tb_symbol_table_engine: done, clean");
    end else begin
      $display("tb_symbol_table_engine: done, errors");
    end
    $finish;
  end

endmodule
